@@ hw/rtl/rgb_box_blur_3x3_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3 assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_BLUR_3X3_ASSERT_SVH
`define RGB_BOX_BLUR_3X3_ASSERT_SVH

// same-cycle implication
`define RBB_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBB_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/rbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the RGB 3x3 box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int CHAN_W        = 8;
   localparam int IMG_W_W       = 11;
   localparam int IMG_H_W       = 16;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;
   localparam int MAX_WIDTH_DEF = 1024;

   localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd1024;
   localparam logic [IMG_H_W-1:0] IMG_H_RESET = 16'd1024;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   // floor(s/9) == (s * 3641) >> 15 for every nine-sample sum s <= 2295
   localparam int SUM_W      = 12;
   localparam int DIV9_MUL_W = 12;
   localparam int DIV9_SHIFT = 15;
   localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

@@ hw/rtl/rbb_if.sv @@
// ----------------------------------------------------------------------------
// rbb_if
// Valid/ready channels of the RGB 3x3 box blur: pixel in, blur out, CSR write.
// ----------------------------------------------------------------------------
interface rbb_pix_if import rbb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rbb_blur_if import rbb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] blur_red;
   logic [CHAN_W-1:0] blur_green;
   logic [CHAN_W-1:0] blur_blue;
   logic              frame_end;

   modport source (output valid, output blur_red, output blur_green, output blur_blue,
                   output frame_end, input ready);
   modport sink   (input valid, input blur_red, input blur_green, input blur_blue,
                   input frame_end, output ready);
endinterface

interface rbb_csr_if import rbb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/rgb_box_blur_3x3.sv @@
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 mean filter on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output register is stalled. Each
// accepted pixel reads both line stores at its column (registered read); when
// it fires from stage one, that logic writes the stores back, shifts the 3x3
// window and forms the nine-sample sums and their truncated mean by 9, which
// goes into the output register. Only pixels whose 3x3 neighborhood is inside
// the frame give a result (rows and columns 0..1 give none), so the result for
// centre (r-1, c-1) follows the pixel at (r, c); frame_end marks the last one
// of a frame. Width is clamped to 3..MAX_WIDTH, height raised to at least 3.
// The line stores are not cleared: the first two rows of the first frame fill
// them. A stalled output register holds the pipeline.
module rgb_box_blur_3x3
   import rbb_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input logic       clock,
   input logic       reset,
   rbb_pix_if.sink   req_chan,
   rbb_blur_if.source rsp_chan,
   rbb_csr_if.sink   csr_chan
);

`include "rgb_box_blur_3x3_assert.svh"

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WW     = (IMG_W_W > COL_W + 1) ? IMG_W_W : COL_W + 1;
   localparam int PROD_W = SUM_W + DIV9_MUL_W;

   // ---------------- configuration ----------------
   logic [IMG_W_W-1:0] width_ff;
   logic [IMG_H_W-1:0] height_ff;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMG_W_RESET;
         height_ff <= IMG_H_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_chan.data[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_chan.data[IMG_H_W-1:0];
            default:          ;
         endcase
      end
   end

   logic [WW-1:0]      w_used;
   logic [IMG_H_W-1:0] h_used;

   always_comb begin
      if (WW'(width_ff) < WW'(3))
         w_used = WW'(3);
      else if (WW'(width_ff) > WW'(MAX_WIDTH))
         w_used = WW'(MAX_WIDTH);
      else
         w_used = WW'(width_ff);
      h_used = (height_ff < IMG_H_W'(3)) ? IMG_H_W'(3) : height_ff;
   end

   // ---------------- handshake ----------------
   logic v1_ff, res1_ff, fe1_ff;
   logic rsp_valid_ff;
   logic fire1, accept;

   assign fire1          = v1_ff && (!res1_ff || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !v1_ff || fire1;
   assign accept         = req_chan.valid && req_chan.ready;

   // ---------------- position counters ----------------
   logic [COL_W-1:0]   c_ff, c_in;
   logic [IMG_H_W-1:0] r_ff, r_in;
   logic [WW-1:0]      c_ext, c_inc;
   logic [IMG_H_W:0]   r_inc;
   logic               has_res, is_fe;

   always_comb begin
      c_ext   = WW'(c_ff);
      c_inc   = c_ext + WW'(1);
      r_inc   = {1'b0, r_ff} + (IMG_H_W + 1)'(1);
      has_res = (r_ff >= IMG_H_W'(2)) && (r_ff < h_used) &&
                (c_ext >= WW'(2)) && (c_ext < w_used);
      is_fe   = (r_ff == h_used - IMG_H_W'(1)) && (c_ext == w_used - WW'(1));
      c_in    = c_ff;
      r_in    = r_ff;
      if (accept) begin
         if (c_inc >= w_used) begin
            c_in = '0;
            r_in = (r_inc >= {1'b0, h_used}) ? '0 : r_inc[IMG_H_W-1:0];
         end else if (r_ff >= h_used) begin
            c_in = '0;
            r_in = '0;
         end else begin
            c_in = c_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff <= '0;
         r_ff <= '0;
      end else begin
         c_ff <= c_in;
         r_ff <= r_in;
      end
   end

   // ---------------- line stores ----------------
   pixel_type older_mem [MAX_WIDTH];
   pixel_type newer_mem [MAX_WIDTH];
   pixel_type top1_ff, mid1_ff, pix1_ff;
   logic [COL_W-1:0] c1_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         top1_ff <= older_mem[c_ff];
         mid1_ff <= newer_mem[c_ff];
      end
      if (fire1) begin
         older_mem[c1_ff] <= mid1_ff;
         newer_mem[c1_ff] <= pix1_ff;
      end
   end

   // ---------------- stage one ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (accept) begin
         v1_ff <= 1'b1;
      end else if (fire1) begin
         v1_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix1_ff <= pixel_type'({req_chan.red, req_chan.green, req_chan.blue});
         c1_ff   <= c_ff;
         res1_ff <= has_res;
         fe1_ff  <= is_fe;
      end
   end

   // window: col_a is column c-2, col_b column c-1; top, middle, bottom
   pixel_type col_a_ff [3];
   pixel_type col_b_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            col_a_ff[i] <= '0;
            col_b_ff[i] <= '0;
         end
      end else if (fire1) begin
         for (int i = 0; i < 3; i++) col_a_ff[i] <= col_b_ff[i];
         col_b_ff[0] <= top1_ff;
         col_b_ff[1] <= mid1_ff;
         col_b_ff[2] <= pix1_ff;
      end
   end

   pixel_type        nine [9];
   logic [SUM_W-1:0] sum_r, sum_g, sum_b;
   logic [PROD_W-1:0] prod_r, prod_g, prod_b;
   pixel_type        mean;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nine[i]     = col_a_ff[i];
         nine[i + 3] = col_b_ff[i];
      end
      nine[6] = top1_ff;
      nine[7] = mid1_ff;
      nine[8] = pix1_ff;
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int i = 0; i < 9; i++) begin
         sum_r = sum_r + SUM_W'(nine[i].red);
         sum_g = sum_g + SUM_W'(nine[i].green);
         sum_b = sum_b + SUM_W'(nine[i].blue);
      end
      prod_r = PROD_W'(sum_r) * PROD_W'(DIV9_MUL);
      prod_g = PROD_W'(sum_g) * PROD_W'(DIV9_MUL);
      prod_b = PROD_W'(sum_b) * PROD_W'(DIV9_MUL);
      mean.red   = prod_r[DIV9_SHIFT +: CHAN_W];
      mean.green = prod_g[DIV9_SHIFT +: CHAN_W];
      mean.blue  = prod_b[DIV9_SHIFT +: CHAN_W];
   end

   // ---------------- output register ----------------
   pixel_type blur_ff;
   logic      fe_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire1 && res1_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire1 && res1_ff) begin
         blur_ff   <= mean;
         fe_out_ff <= fe1_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.blur_red   = blur_ff.red;
   assign rsp_chan.blur_green = blur_ff.green;
   assign rsp_chan.blur_blue  = blur_ff.blue;
   assign rsp_chan.frame_end  = fe_out_ff;

   // ---------------- assertions ----------------
   `RBB_ASSERT_IMP(a_rsp_from_stage1, $rose(rsp_valid_ff), $past(v1_ff && res1_ff),
      "result appeared without a stage-one item that has one")
   `RBB_ASSERT_NXT(a_stage1_holds, v1_ff && !fire1, v1_ff && $stable(c1_ff) && $stable(res1_ff),
      "stalled stage-one item was lost or changed")
   `RBB_ASSERT_NXT(a_frame_wrap, accept && is_fe, (r_ff == '0) && (c_ff == '0),
      "position did not wrap after the last pixel of a frame")

endmodule
